### hdl/tta_pkg.sv
// Shared types and constants for the tap tempo averager.
`timescale 1ns / 1ps

package tta_pkg;

  localparam int TIME_W = 32;
  localparam int INTERVAL_W = 16;
  localparam int TEMPO_W = 20;
  localparam int FRAC_W = 4;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_VALID_TAPS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 1'd1;

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 16'd50;
  localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RESET = 16'd2000;

  typedef struct packed {
    logic accept;
    logic eval;
    logic div_start;
    logic div_step;
    logic load_out;
  } tta_cmd_t;

  typedef struct packed {
    logic selected;
    logic in_window;
    logic enough;
    logic div_done;
  } tta_status_t;

endpackage

### hdl/tta_ctrl.sv
// Controller state machine that sequences one tap through the datapath.
`timescale 1ns / 1ps

module tta_ctrl
  import tta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  tta_status_t status,
  output tta_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (status.selected && status.in_window && status.enough) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/tta_datapath.sv
// Datapath: timestamp, interval window, ring of intervals, running sum and serial divider.
`timescale 1ns / 1ps

module tta_datapath
  import tta_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  tta_cmd_t              cmd,
  output tta_status_t           status,
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = INTERVAL_W + $clog2(RING_DEPTH);
  localparam int Q_W = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(Q_W + 1);

  logic [INTERVAL_W-1:0] min_interval;
  logic [INTERVAL_W-1:0] max_interval;
  logic [TIME_W-1:0]     last_tap_time;
  logic [TIME_W-1:0]     gap;
  logic                  selected;
  logic [INTERVAL_W-1:0] ring [RING_DEPTH];
  logic [SLOT_W-1:0]     write_slot;
  logic [CNT_W-1:0]      valid_count;
  logic [CNT_W-1:0]      count_next;
  logic [SUM_W-1:0]      interval_sum;
  logic [INTERVAL_W-1:0] old_entry;
  logic                  full;
  logic [Q_W-1:0]        quot;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W:0]        rem_shift;
  logic [CNT_W:0]        rem_diff;
  logic [STEP_W-1:0]     steps;
  logic [TEMPO_W-1:0]    tempo;

  assign full = (valid_count == CNT_W'(RING_DEPTH));
  assign count_next = full ? valid_count : valid_count + 1'b1;
  assign old_entry = full ? ring[write_slot] : '0;

  assign status.selected = selected;
  assign status.in_window = (gap > TIME_W'(min_interval)) && (gap < TIME_W'(max_interval));
  assign status.enough = (count_next >= CNT_W'(MIN_VALID_TAPS));
  assign status.div_done = (steps == '0);

  assign rem_shift = {rem, quot[Q_W-1]};
  assign rem_diff = rem_shift - {1'b0, valid_count};

  assign m_tdata = {{(M_TDATA_W - TEMPO_W){1'b0}}, tempo};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RESET;
      max_interval <= MAX_INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_INTERVAL: min_interval <= cfg_data;
        REG_MAX_INTERVAL: max_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tap_time <= '0;
      write_slot <= '0;
      valid_count <= '0;
      interval_sum <= '0;
      steps <= '0;
    end else begin
      if (cmd.accept) begin
        last_tap_time <= s_tdata[TIME_W-1:0];
      end
      if (cmd.eval && selected) begin
        if (status.in_window) begin
          valid_count <= count_next;
          interval_sum <= interval_sum - SUM_W'(old_entry) + SUM_W'(gap[INTERVAL_W-1:0]);
          write_slot <= (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        end else begin
          valid_count <= '0;
          interval_sum <= '0;
          write_slot <= '0;
        end
      end
      if (cmd.div_start) begin
        steps <= STEP_W'(Q_W);
      end else if (cmd.div_step) begin
        steps <= steps - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      gap <= s_tdata[TIME_W-1:0] - last_tap_time;
      selected <= s_tuser[0];
    end
    if (cmd.eval && selected && status.in_window) begin
      ring[write_slot] <= gap[INTERVAL_W-1:0];
    end
    if (cmd.div_start) begin
      quot <= {interval_sum - SUM_W'(old_entry) + SUM_W'(gap[INTERVAL_W-1:0]), {FRAC_W{1'b0}}};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!rem_diff[CNT_W]) begin
        rem <= rem_diff[CNT_W-1:0];
        quot <= {quot[Q_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CNT_W-1:0];
        quot <= {quot[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      tempo <= quot[TEMPO_W-1:0];
    end
  end

endmodule

### hdl/tap_tempo_averager_core.sv
// Top level of the tap tempo averager: controller and datapath.
//
// Each transaction on the s_ channel is one tap: s_tdata carries the 32-bit
// millisecond timestamp and s_tuser flags that the delay effect is selected.
// The timestamp is always recorded. For a selected tap the interval since the
// previous tap is checked against the open window set by the two configuration
// registers; a good interval enters the ring, a bad one clears it. Once four or
// more intervals are held, the average interval goes out on the m_ channel as
// an unsigned Q16.4 value, truncated.
// A tap that gives no result goes back to idle after its evaluation; one that
// does passes through the bit-serial divider, which retires one quotient bit
// per cycle. One tap is processed at a time.
// The output register holds a result until it is taken; while the receiver
// stalls, the next tap is still accepted and worked on, and its result waits
// in the divider until the output register is free.
// Reset restores the window to 50 and 2000 ms and empties the ring.
// The configuration channel is always ready and should be written while idle.
`timescale 1ns / 1ps

module tap_tempo_averager_core
  import tta_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] tap_time
  input  logic [0:0]            s_tuser,   // [0] delay_selected
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [19:0] tempo, [23:20] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tta_cmd_t    cmd;
  tta_status_t status;

  assign cfg_ready = 1'b1;

  tta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tta_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule
